// ===== rtl/ibb_pkg.sv =====
// ibb_pkg: widths, register indexes and shared structs of the image block binning block
// used by every module in rtl/, depends on nothing

package ibb_pkg;

   localparam int POS_W      = 12;   // input row/column position
   localparam int BIN_W      = 5;    // bin size register
   localparam int ORES_W     = 9;    // output rows/cols register
   localparam int IRES_W     = 13;   // input rows/cols register
   localparam int LIM_W      = 14;   // out_* times bin_* product
   localparam int SUM_W      = 24;   // block sums
   localparam int OIDX_W     = 8;    // out_row / out_col fields
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int RSP_DATA_W = 40;   // bin_sum, out_row, out_col

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BIN_ROWS = 3'd0,
      REG_BIN_COLS = 3'd1,
      REG_OUT_ROWS = 3'd2,
      REG_OUT_COLS = 3'd3,
      REG_IN_ROWS  = 3'd4,
      REG_IN_COLS  = 3'd5
   } csr_reg_type;

   // clamped configuration and derived limits
   typedef struct packed {
      logic [BIN_W-1:0]  br;
      logic [BIN_W-1:0]  bc;
      logic [ORES_W-1:0] orows;
      logic [ORES_W-1:0] ocols;
      logic [IRES_W-1:0] irows;
      logic [IRES_W-1:0] icols;
      logic [LIM_W-1:0]  row_lim;
      logic [LIM_W-1:0]  col_lim;
   } cfg_type;

   // block counters rebuilt from the positions after a register write
   typedef struct packed {
      logic             load;
      logic [BIN_W-1:0] rb;
      logic [POS_W-1:0] orow;
      logic [BIN_W-1:0] cb;
      logic [POS_W-1:0] ocol;
   } pos_fix_type;

endpackage

// ===== rtl/ibb_csr.sv =====
// ibb_csr: configuration registers with range clamping and registered limit products
// depends on ibb_pkg

module ibb_csr #(
   parameter int MAX_OUT_COLS = 256,
   parameter int MAX_BIN      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ibb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ibb_pkg::CSR_DATA_W-1:0]    csr_data,
   output ibb_pkg::cfg_type                  cfg,
   output logic                              recalc
);

   localparam int OCAP = (MAX_OUT_COLS < 256) ? MAX_OUT_COLS : 256;

   function automatic logic [ibb_pkg::BIN_W-1:0] clamp_bin(input logic [ibb_pkg::BIN_W-1:0] v);
      logic [ibb_pkg::BIN_W-1:0] r;
      r = v;
      if (v == '0) r = ibb_pkg::BIN_W'(1);
      else if (int'(v) > MAX_BIN) r = ibb_pkg::BIN_W'(MAX_BIN);
      return r;
   endfunction

   function automatic logic [ibb_pkg::ORES_W-1:0] clamp_out(input logic [ibb_pkg::ORES_W-1:0] v,
                                                            input int hi);
      logic [ibb_pkg::ORES_W-1:0] r;
      r = v;
      if (v == '0) r = ibb_pkg::ORES_W'(1);
      else if (int'(v) > hi) r = ibb_pkg::ORES_W'(hi);
      return r;
   endfunction

   function automatic logic [ibb_pkg::IRES_W-1:0] clamp_in(input logic [ibb_pkg::IRES_W-1:0] v);
      logic [ibb_pkg::IRES_W-1:0] r;
      r = v;
      if (v == '0) r = ibb_pkg::IRES_W'(1);
      else if (int'(v) > 4096) r = ibb_pkg::IRES_W'(4096);
      return r;
   endfunction

   localparam logic [ibb_pkg::BIN_W-1:0]  BIN_RST  = clamp_bin(ibb_pkg::BIN_W'(2));
   localparam logic [ibb_pkg::ORES_W-1:0] OROW_RST = ibb_pkg::ORES_W'(256);
   localparam logic [ibb_pkg::ORES_W-1:0] OCOL_RST = clamp_out(ibb_pkg::ORES_W'(256), OCAP);
   localparam logic [ibb_pkg::IRES_W-1:0] IN_RST   = ibb_pkg::IRES_W'(512);

   logic [ibb_pkg::BIN_W-1:0]  br_ff, bc_ff;
   logic [ibb_pkg::ORES_W-1:0] orows_ff, ocols_ff;
   logic [ibb_pkg::IRES_W-1:0] irows_ff, icols_ff;
   logic [ibb_pkg::LIM_W-1:0]  row_lim_ff, col_lim_ff;
   logic                       recalc_ff;
   logic                       wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         br_ff      <= BIN_RST;
         bc_ff      <= BIN_RST;
         orows_ff   <= OROW_RST;
         ocols_ff   <= OCOL_RST;
         irows_ff   <= IN_RST;
         icols_ff   <= IN_RST;
         row_lim_ff <= ibb_pkg::LIM_W'(OROW_RST) * ibb_pkg::LIM_W'(BIN_RST);
         col_lim_ff <= ibb_pkg::LIM_W'(OCOL_RST) * ibb_pkg::LIM_W'(BIN_RST);
         recalc_ff  <= 1'b0;
      end else begin
         recalc_ff  <= wr;
         row_lim_ff <= ibb_pkg::LIM_W'(orows_ff) * ibb_pkg::LIM_W'(br_ff);
         col_lim_ff <= ibb_pkg::LIM_W'(ocols_ff) * ibb_pkg::LIM_W'(bc_ff);
         if (wr) begin
            case (csr_index)
               ibb_pkg::REG_BIN_ROWS: br_ff    <= clamp_bin(csr_data[ibb_pkg::BIN_W-1:0]);
               ibb_pkg::REG_BIN_COLS: bc_ff    <= clamp_bin(csr_data[ibb_pkg::BIN_W-1:0]);
               ibb_pkg::REG_OUT_ROWS: orows_ff <= clamp_out(csr_data[ibb_pkg::ORES_W-1:0], 256);
               ibb_pkg::REG_OUT_COLS: ocols_ff <= clamp_out(csr_data[ibb_pkg::ORES_W-1:0], OCAP);
               ibb_pkg::REG_IN_ROWS:  irows_ff <= clamp_in(csr_data);
               ibb_pkg::REG_IN_COLS:  icols_ff <= clamp_in(csr_data);
               default: ;
            endcase
         end
      end
   end

   assign recalc      = recalc_ff;
   assign cfg.br      = br_ff;
   assign cfg.bc      = bc_ff;
   assign cfg.orows   = orows_ff;
   assign cfg.ocols   = ocols_ff;
   assign cfg.irows   = irows_ff;
   assign cfg.icols   = icols_ff;
   assign cfg.row_lim = row_lim_ff;
   assign cfg.col_lim = col_lim_ff;

endmodule

// ===== rtl/ibb_div.sv =====
// ibb_div: one-bit-per-cycle restoring divider, position by bin size
// depends on ibb_pkg

module ibb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ibb_pkg::POS_W-1:0]    dividend,
   input  logic [ibb_pkg::BIN_W-1:0]    divisor,
   output logic                         busy,
   output logic                         done,
   output logic [ibb_pkg::POS_W-1:0]    quot,
   output logic [ibb_pkg::BIN_W-1:0]    rem
);

   localparam int CNT_W = $clog2(ibb_pkg::POS_W);

   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff, done_ff;
   logic [ibb_pkg::POS_W-1:0]   num_ff;
   logic [ibb_pkg::BIN_W-1:0]   rem_ff, dsr_ff;
   logic [ibb_pkg::BIN_W:0]     rem_sh, rem_sub;
   logic                        take;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[ibb_pkg::POS_W-1]};
      take    = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ibb_pkg::POS_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[ibb_pkg::POS_W-2:0], take};
         rem_ff <= take ? rem_sub[ibb_pkg::BIN_W-1:0] : rem_sh[ibb_pkg::BIN_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/ibb_core.sv =====
// ibb_core: position counters, row accumulator, column line store and result register
// depends on ibb_pkg

module ibb_core #(
   parameter int MAX_OUT_COLS = 256,
   parameter int PIXEL_BITS   = 16,
   parameter int DATA_W       = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ibb_pkg::cfg_type                  cfg,
   input  ibb_pkg::pos_fix_type              fix,
   input  logic                              hold,
   output logic [ibb_pkg::POS_W-1:0]         pos_row,
   output logic [ibb_pkg::POS_W-1:0]         pos_col,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_W-1:0]                 req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ibb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int IDX_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
   localparam int PW    = ibb_pkg::POS_W;
   localparam int BW    = ibb_pkg::BIN_W;
   localparam int SW    = ibb_pkg::SUM_W;
   localparam int OW    = ibb_pkg::OIDX_W;

   // position and block counters
   logic [PW-1:0] r_ff, c_ff, orow_ff, ocol_ff;
   logic [PW-1:0] r_in, c_in, orow_in, ocol_in;
   logic [BW-1:0] rb_ff, cb_ff, rb_in, cb_in;
   logic [SW-1:0] acc_ff, acc_in;

   // item stage
   logic              s1_valid_ff, s1_emit_ff, s1_rb0_ff, s1_last_ff;
   logic [SW-1:0]     s1_acc_ff;
   logic [OW-1:0]     s1_orow_ff, s1_ocol_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [SW-1:0]     rd_ff;

   // result register
   logic              o_valid_ff, o_last_ff;
   logic [SW-1:0]     o_sum_ff;
   logic [OW-1:0]     o_row_ff, o_col_ff;

   logic [SW-1:0]     line_mem [MAX_OUT_COLS];

   logic              accept, s1_adv, in_area, cb_end, rb_end, blk_end, last_hit;
   logic              row_wrap, frame_wrap, wr_en;
   logic [PW:0]       c_inc, r_inc;
   logic [SW-1:0]     pix, total;
   logic [IDX_W-1:0]  rd_idx;

   assign s1_adv     = !s1_valid_ff || !s1_emit_ff || !o_valid_ff || rsp_tready;
   assign req_tready = !hold && s1_adv;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pix        = SW'(req_tdata[PIXEL_BITS-1:0]);
      in_area    = ({1'b0, r_ff} < cfg.irows) && ({1'b0, c_ff} < cfg.icols) &&
                   ({2'b0, r_ff} < cfg.row_lim) && ({2'b0, c_ff} < cfg.col_lim);
      cb_end     = ({1'b0, cb_ff} + (BW+1)'(1)) == {1'b0, cfg.bc};
      rb_end     = ({1'b0, rb_ff} + (BW+1)'(1)) == {1'b0, cfg.br};
      blk_end    = in_area && cb_end;
      last_hit   = ({1'b0, orow_ff} == ({4'b0, cfg.orows} - 13'd1)) &&
                   ({1'b0, ocol_ff} == ({4'b0, cfg.ocols} - 13'd1));
      rd_idx     = ocol_ff[IDX_W-1:0];
      acc_in     = (cb_ff == '0) ? pix : acc_ff + pix;

      c_inc      = {1'b0, c_ff} + (PW+1)'(1);
      r_inc      = {1'b0, r_ff} + (PW+1)'(1);
      row_wrap   = c_inc >= cfg.icols;
      frame_wrap = r_inc >= cfg.irows;

      r_in    = r_ff;
      c_in    = c_ff;
      rb_in   = rb_ff;
      cb_in   = cb_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (fix.load) begin
         rb_in   = fix.rb;
         cb_in   = fix.cb;
         orow_in = fix.orow;
         ocol_in = fix.ocol;
      end else if (accept) begin
         if (row_wrap) begin
            c_in    = '0;
            cb_in   = '0;
            ocol_in = '0;
            if (frame_wrap) begin
               r_in    = '0;
               rb_in   = '0;
               orow_in = '0;
            end else begin
               r_in = r_inc[PW-1:0];
               if (rb_end) begin
                  rb_in   = '0;
                  orow_in = orow_ff + PW'(1);
               end else begin
                  rb_in = rb_ff + BW'(1);
               end
            end
         end else begin
            c_in = c_inc[PW-1:0];
            if (cb_end) begin
               cb_in   = '0;
               ocol_in = ocol_ff + PW'(1);
            end else begin
               cb_in = cb_ff + BW'(1);
            end
         end
      end

      total = s1_rb0_ff ? s1_acc_ff : rd_ff + s1_acc_ff;
      wr_en = s1_valid_ff && !s1_emit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff        <= '0;
         c_ff        <= '0;
         rb_ff       <= '0;
         cb_ff       <= '0;
         orow_ff     <= '0;
         ocol_ff     <= '0;
         acc_ff      <= '0;
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         r_ff    <= r_in;
         c_ff    <= c_in;
         rb_ff   <= rb_in;
         cb_ff   <= cb_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         if (accept && in_area) acc_ff <= acc_in;

         if (accept) s1_valid_ff <= blk_end;
         else if (s1_adv) s1_valid_ff <= 1'b0;

         if (s1_valid_ff && s1_emit_ff && (!o_valid_ff || rsp_tready)) o_valid_ff <= 1'b1;
         else if (rsp_tready) o_valid_ff <= 1'b0;
      end
   end

   // payload of the item stage and the result register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= rb_end;
         s1_rb0_ff  <= (rb_ff == '0);
         s1_last_ff <= last_hit;
         s1_acc_ff  <= acc_in;
         s1_orow_ff <= orow_ff[OW-1:0];
         s1_ocol_ff <= ocol_ff[OW-1:0];
         s1_idx_ff  <= rd_idx;
      end
      if (s1_valid_ff && s1_emit_ff && (!o_valid_ff || rsp_tready)) begin
         o_sum_ff  <= total;
         o_row_ff  <= s1_orow_ff;
         o_col_ff  <= s1_ocol_ff;
         o_last_ff <= s1_last_ff;
      end
   end

   // line store, partial column sums; same-column write forwards into the read
   always_ff @(posedge clock) begin
      if (wr_en) line_mem[s1_idx_ff] <= total;
      if (accept) begin
         if (wr_en && (s1_idx_ff == rd_idx)) rd_ff <= total;
         else rd_ff <= line_mem[rd_idx];
      end
   end

   assign pos_row    = r_ff;
   assign pos_col    = c_ff;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_col_ff, o_row_ff, o_sum_ff};
   assign rsp_tlast  = o_last_ff;

endmodule

// ===== rtl/image_block_binning.sv =====
// image_block_binning: box binning of a raster pixel stream into block sums
// a pixel that completes a block reaches rsp through the item stage and then the result register
// throughput: one pixel per cycle; input stalls only during a counter rebuild, or while a result
// waits on rsp and a second completed block waits behind it in the item stage
// after each configuration write, input pauses while the bin counters are rebuilt
// from the positions by the one-bit-per-cycle row and column dividers
// reset: synchronous, active high; clears positions, counters, registers; line store not cleared

module image_block_binning #(
   parameter int MAX_OUT_COLS = 256,
   parameter int PIXEL_BITS   = 16,
   parameter int MAX_BIN      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]   req_tdata,   // pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ibb_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // bin_sum, out_row, out_col
   output logic                              rsp_tlast,   // last_of_frame
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ibb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ibb_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DATA_W = ((PIXEL_BITS+7)/8)*8;

   ibb_pkg::cfg_type              cfg;
   ibb_pkg::pos_fix_type          fix;
   logic                          recalc, hold;
   logic                          row_busy, row_done, col_busy, col_done;
   logic [ibb_pkg::POS_W-1:0]     pos_row, pos_col, orow_q, ocol_q;
   logic [ibb_pkg::BIN_W-1:0]     rb_q, cb_q;

   ibb_csr #(
      .MAX_OUT_COLS (MAX_OUT_COLS),
      .MAX_BIN      (MAX_BIN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .recalc    (recalc)
   );

   ibb_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (recalc),
      .dividend (pos_row),
      .divisor  (cfg.br),
      .busy     (row_busy),
      .done     (row_done),
      .quot     (orow_q),
      .rem      (rb_q)
   );

   ibb_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (recalc),
      .dividend (pos_col),
      .divisor  (cfg.bc),
      .busy     (col_busy),
      .done     (col_done),
      .quot     (ocol_q),
      .rem      (cb_q)
   );

   // both dividers run in lockstep
   assign hold     = recalc || row_busy || row_done || col_busy || col_done;
   assign fix.load = row_done;
   assign fix.rb   = rb_q;
   assign fix.orow = orow_q;
   assign fix.cb   = cb_q;
   assign fix.ocol = ocol_q;

   ibb_core #(
      .MAX_OUT_COLS (MAX_OUT_COLS),
      .PIXEL_BITS   (PIXEL_BITS),
      .DATA_W       (DATA_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fix        (fix),
      .hold       (hold),
      .pos_row    (pos_row),
      .pos_col    (pos_col),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/ibb_checker.sv =====
// ibb_checker: port-level assertions for image_block_binning, attached by bind
// depends on ibb_pkg and the top level's ports

module ibb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ibb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // a register write pauses input at the start of the counter rebuild
   a_csr_pause: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready ##1 !req_tready)
      else $error("input accepted during counter rebuild");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind image_block_binning ibb_checker u_ibb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

// ===== tb/image_block_binning_tb.sv =====
// image_block_binning_tb: self-checking testbench for the image block binning block
// drives raster pixels and register writes, predicts every block sum, checks each result
// depends on rtl/ibb_pkg.sv and rtl/image_block_binning.sv
`timescale 1ns / 1ps

module image_block_binning_tb;

   localparam int MAX_OUT_COLS = 256;
   localparam int PIXEL_BITS   = 16;
   localparam int MAX_BIN      = 16;
   localparam int STIM_ITEMS   = 1950;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LS_IDX_W     = $clog2(MAX_OUT_COLS);

   typedef struct packed {
      logic [ibb_pkg::SUM_W-1:0]  sum;
      logic [ibb_pkg::OIDX_W-1:0] row;
      logic [ibb_pkg::OIDX_W-1:0] col;
      logic                       last;
   } bin_result_type;

   typedef enum logic [0:0] {STEP_CSR, STEP_PIX} step_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} check_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      ibb_pkg::csr_reg_type reg_idx;
      logic [15:0]          value;
      check_kind_type       check;
      bin_result_type       want;
   } step_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [15:0]                    req_tdata;    // pixel
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ibb_pkg::RSP_DATA_W-1:0] rsp_tdata;    // bin_sum, out_row, out_col
   logic                           rsp_tlast;    // last_of_frame
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ibb_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ibb_pkg::CSR_DATA_W-1:0] csr_data;

   // binning state and register copy, at their reset values
   logic [ibb_pkg::BIN_W-1:0]  bin_rows_reg = 5'd2;
   logic [ibb_pkg::BIN_W-1:0]  bin_cols_reg = 5'd2;
   logic [ibb_pkg::ORES_W-1:0] out_rows_reg = 9'd256;
   logic [ibb_pkg::ORES_W-1:0] out_cols_reg = 9'd256;
   logic [ibb_pkg::IRES_W-1:0] in_rows_reg  = 13'd512;
   logic [ibb_pkg::IRES_W-1:0] in_cols_reg  = 13'd512;
   logic [ibb_pkg::SUM_W-1:0]  line_sums [MAX_OUT_COLS];
   logic [ibb_pkg::POS_W-1:0]  row_pos   = '0;
   logic [ibb_pkg::POS_W-1:0]  col_pos   = '0;
   logic [ibb_pkg::SUM_W-1:0]  block_acc = '0;

   bin_result_type expected_bins [$];
   step_type       steps [$];
   int             errors     = 0;
   int             stim_items = 0;
   int             cycles     = 0;
   bit             hold_req   = 1'b0;
   bit             hold_done  = 1'b0;

   image_block_binning #(
      .MAX_OUT_COLS(MAX_OUT_COLS),
      .PIXEL_BITS  (PIXEL_BITS),
      .MAX_BIN     (MAX_BIN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_bin();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(17, 31);
      if (r == 2) return 16;
      return $urandom_range(1, 4);
   endfunction

   // advances the binning state by one pixel, returns 1 when a block completes
   function automatic bit bin_pixel(input logic [15:0] pix, output bin_result_type res);
      int br, bc, orows, ocols, irows, icols;
      int r, c, rb, cb, orow, ocol, idx;
      logic [ibb_pkg::SUM_W-1:0] total;
      bit hit;
      br    = clamp(bin_rows_reg, 1, MAX_BIN);
      bc    = clamp(bin_cols_reg, 1, MAX_BIN);
      orows = clamp(out_rows_reg, 1, 256);
      ocols = clamp(out_cols_reg, 1, (MAX_OUT_COLS < 256) ? MAX_OUT_COLS : 256);
      irows = clamp(in_rows_reg, 1, 4096);
      icols = clamp(in_cols_reg, 1, 4096);
      r     = row_pos;
      c     = col_pos;
      hit   = 1'b0;
      res   = '0;
      if (r < irows && c < icols && r < orows * br && c < ocols * bc) begin
         orow = r / br;
         rb   = r % br;
         ocol = c / bc;
         cb   = c % bc;
         idx  = ocol % MAX_OUT_COLS;
         if (cb == 0) begin
            block_acc = {8'd0, pix};
         end else begin
            block_acc = block_acc + {8'd0, pix};
         end
         if (cb == bc - 1) begin
            total = (rb == 0) ? block_acc : line_sums[idx[LS_IDX_W-1:0]] + block_acc;
            if (rb == br - 1) begin
               res.sum  = total;
               res.row  = orow[7:0];
               res.col  = ocol[7:0];
               res.last = (orow == orows - 1 && ocol == ocols - 1);
               hit      = 1'b1;
            end else begin
               line_sums[idx[LS_IDX_W-1:0]] = total;
            end
         end
      end
      c = c + 1;
      if (c >= icols) begin
         c = 0;
         r = r + 1;
         if (r >= irows) r = 0;
      end
      row_pos = r[ibb_pkg::POS_W-1:0];
      col_pos = c[ibb_pkg::POS_W-1:0];
      return hit;
   endfunction

   function automatic void add_csr(input ibb_pkg::csr_reg_type idx, input logic [12:0] v);
      step_type st;
      st         = '0;
      st.kind    = STEP_CSR;
      st.reg_idx = idx;
      st.value   = {3'd0, v};
      steps.push_back(st);
   endfunction

   function automatic void add_pix(input logic [15:0] p, input check_kind_type ck,
                                   input logic [23:0] s, input logic [7:0] row,
                                   input logic [7:0] col, input logic last);
      step_type st;
      st           = '0;
      st.kind      = STEP_PIX;
      st.value     = p;
      st.check     = ck;
      st.want.sum  = s;
      st.want.row  = row;
      st.want.col  = col;
      st.want.last = last;
      steps.push_back(st);
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // waits until every expected result is out and the pipeline has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input ibb_pkg::csr_reg_type idx, input logic [12:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ibb_pkg::REG_BIN_ROWS: bin_rows_reg = value[ibb_pkg::BIN_W-1:0];
         ibb_pkg::REG_BIN_COLS: bin_cols_reg = value[ibb_pkg::BIN_W-1:0];
         ibb_pkg::REG_OUT_ROWS: out_rows_reg = value[ibb_pkg::ORES_W-1:0];
         ibb_pkg::REG_OUT_COLS: out_cols_reg = value[ibb_pkg::ORES_W-1:0];
         ibb_pkg::REG_IN_ROWS:  in_rows_reg  = value[ibb_pkg::IRES_W-1:0];
         ibb_pkg::REG_IN_COLS:  in_cols_reg  = value[ibb_pkg::IRES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [15:0] pix, input check_kind_type check,
                             input bin_result_type want, input int gap);
      bin_result_type pred;
      bit hit;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      hit = bin_pixel(pix, pred);
      if (check == CHECK_TYPED) begin
         expected_bins.push_back(want);
      end else if (check == CHECK_MODEL && hit) begin
         expected_bins.push_back(pred);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_phase(input logic [12:0] br, input logic [12:0] bc,
                            input logic [12:0] orows, input logic [12:0] ocols,
                            input logic [12:0] irows, input logic [12:0] icols,
                            input int n, input bit saturate, input bit no_idle);
      logic [15:0] pix;
      int r;
      csr_write(ibb_pkg::REG_BIN_ROWS, br);
      csr_write(ibb_pkg::REG_BIN_COLS, bc);
      csr_write(ibb_pkg::REG_OUT_ROWS, orows);
      csr_write(ibb_pkg::REG_OUT_COLS, ocols);
      csr_write(ibb_pkg::REG_IN_ROWS, irows);
      csr_write(ibb_pkg::REG_IN_COLS, icols);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 7);
         if (saturate || r == 1) begin
            pix = 16'hFFFF;
         end else if (r == 0) begin
            pix = 16'h0000;
         end else begin
            pix = 16'($urandom_range(0, 16'hFFFF));
         end
         send_pixel(pix, CHECK_MODEL, '0, no_idle ? 0 : pick_gap());
         stim_items++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      bin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bins.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[23:0], 24'd0);
         end else begin
            want = expected_bins.pop_front();
            if (rsp_tdata[23:0] !== want.sum)
               report_mismatch("bin_sum", rsp_tdata[23:0], want.sum);
            if (rsp_tdata[31:24] !== want.row)
               report_mismatch("out_row", {16'd0, rsp_tdata[31:24]}, {16'd0, want.row});
            if (rsp_tdata[39:32] !== want.col)
               report_mismatch("out_col", {16'd0, rsp_tdata[39:32]}, {16'd0, want.col});
            if (rsp_tlast !== want.last)
               report_mismatch("last_of_frame", {23'd0, rsp_tlast}, {23'd0, want.last});
         end
      end
   end

   // result side pacing, with one long hold-off on request
   initial begin : rsp_pacing
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int frame;
      int n;
      int e_br, e_bc, e_or, e_oc;
      logic [12:0] br, bc, orows, ocols, irows, icols;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= ibb_pkg::REG_BIN_ROWS;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 2x2 block from the reset bin sizes, all pixels at full scale
      add_csr(ibb_pkg::REG_IN_COLS, 13'd2);
      add_csr(ibb_pkg::REG_IN_ROWS, 13'd2);
      add_csr(ibb_pkg::REG_OUT_ROWS, 13'd1);
      add_csr(ibb_pkg::REG_OUT_COLS, 13'd1);
      add_pix(16'hFFFF, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'hFFFF, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'hFFFF, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'hFFFF, CHECK_TYPED, 24'd262140, 8'd0, 8'd0, 1'b1);
      // 1x1 bins pass each pixel through
      add_csr(ibb_pkg::REG_BIN_ROWS, 13'd1);
      add_csr(ibb_pkg::REG_BIN_COLS, 13'd1);
      add_csr(ibb_pkg::REG_IN_ROWS, 13'd1);
      add_csr(ibb_pkg::REG_IN_COLS, 13'd1);
      add_pix(16'h0000, CHECK_TYPED, 24'd0, 8'd0, 8'd0, 1'b1);
      add_pix(16'hFFFF, CHECK_TYPED, 24'd65535, 8'd0, 8'd0, 1'b1);
      add_pix(16'hA5A5, CHECK_TYPED, 24'd42405, 8'd0, 8'd0, 1'b1);
      add_pix(16'h5A5A, CHECK_TYPED, 24'd23130, 8'd0, 8'd0, 1'b1);
      // zero bin rows clamps to one, trailing column past the binned area dropped
      add_csr(ibb_pkg::REG_BIN_ROWS, 13'd0);
      add_csr(ibb_pkg::REG_BIN_COLS, 13'd3);
      add_csr(ibb_pkg::REG_OUT_COLS, 13'd2);
      add_csr(ibb_pkg::REG_IN_COLS, 13'd7);
      add_pix(16'd1, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'd2, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'd3, CHECK_TYPED, 24'd6, 8'd0, 8'd0, 1'b0);
      add_pix(16'd10, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'd20, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'd30, CHECK_TYPED, 24'd60, 8'd0, 8'd1, 1'b1);
      add_pix(16'hFFFF, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      // block wider than the input never completes
      add_csr(ibb_pkg::REG_BIN_COLS, 13'd31);
      add_csr(ibb_pkg::REG_IN_COLS, 13'd0);
      add_pix(16'd7, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'd8, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'hFFFF, CHECK_NONE, 24'd0, 8'd0, 8'd0, 1'b0);
      add_csr(ibb_pkg::REG_BIN_COLS, 13'd2);
      add_csr(ibb_pkg::REG_IN_COLS, 13'd4);
      add_pix(16'h1234, CHECK_MODEL, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'hFEDC, CHECK_MODEL, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'h8001, CHECK_MODEL, 24'd0, 8'd0, 8'd0, 1'b0);
      add_pix(16'h7FFE, CHECK_MODEL, 24'd0, 8'd0, 8'd0, 1'b0);

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            csr_write(steps[i].reg_idx, steps[i].value[12:0]);
         end else begin
            send_pixel(steps[i].value, steps[i].check, steps[i].want, pick_gap());
         end
      end

      // fill every line store entry once, so later mid-frame changes read known data
      run_phase(13'd2, 13'd1, 13'd256, 13'd256, 13'd1, 13'd256, 256, 1'b0, 1'b0);

      phase = 0;
      while (stim_items < STIM_ITEMS) begin
         phase++;
         if (phase == 3) begin
            // largest block at full scale gives the maximum sum
            run_phase(13'd16, 13'd16, 13'd1, 13'd1, 13'd16, 13'd16, 256, 1'b1, 1'b0);
         end else if (phase == 6) begin
            // full width row while the result side holds off
            hold_req = 1'b1;
            run_phase(13'd1, 13'd1, 13'd1, 13'd256, 13'd1, 13'd300, 300, 1'b0, 1'b1);
         end else if (phase == 9) begin
            run_phase(13'd1, 13'd1, 13'd511, 13'd1, 13'd256, 13'd1, 256, 1'b0, 1'b0);
         end else begin
            br = 13'(pick_bin());
            bc = 13'(pick_bin());
            case ($urandom_range(0, 9))
               0:       orows = 13'd0;
               1:       orows = 13'($urandom_range(257, 511));
               default: orows = 13'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
               0:       ocols = 13'd0;
               1:       ocols = 13'($urandom_range(257, 511));
               default: ocols = 13'($urandom_range(1, 6));
            endcase
            e_br = clamp(br[4:0], 1, MAX_BIN);
            e_bc = clamp(bc[4:0], 1, MAX_BIN);
            e_or = clamp(orows[8:0], 1, 256);
            e_oc = clamp(ocols[8:0], 1, 256);
            case ($urandom_range(0, 9))
               0:       irows = 13'd0;
               1:       irows = 13'($urandom_range(4097, 8191));
               2:       irows = 13'($urandom_range(1, e_or * e_br));
               default: irows = 13'(e_or * e_br + $urandom_range(0, 2));
            endcase
            case ($urandom_range(0, 9))
               0:       icols = 13'd0;
               1:       icols = 13'($urandom_range(4097, 8191));
               2:       icols = 13'($urandom_range(1, e_oc * e_bc));
               default: icols = 13'(e_oc * e_bc + $urandom_range(0, 2));
            endcase
            frame = clamp(irows, 1, 4096) * clamp(icols, 1, 4096);
            // whole frames mostly, sometimes a partial one so the next write lands mid-frame
            if (frame <= 160 && $urandom_range(0, 4) != 0) begin
               n = frame * $urandom_range(1, 3);
            end else begin
               n = $urandom_range(1, 120);
            end
            if (n > STIM_ITEMS - stim_items) n = STIM_ITEMS - stim_items;
            run_phase(br, bc, orows, ocols, irows, icols, n, 1'b0,
                      $urandom_range(0, 3) == 0);
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ibb_pkg.sv
rtl/ibb_csr.sv
rtl/ibb_div.sv
rtl/ibb_core.sv
rtl/image_block_binning.sv
rtl/ibb_checker.sv
tb/image_block_binning_tb.sv
